### hw/rtl/nps3d_pkg.sv
package nps3d_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int COORD_BITS = 16;

    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 12;
    localparam int DIST_W  = 36;
    localparam int OP_W    = 2;
    localparam int PT_W    = 3 * COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + 2;
    localparam int EXT_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] LIMIT_RESET = 36'd65536000000;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

### hw/rtl/nps3d_ram.sv
module nps3d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/nearest_point_search_3d_unit.sv
// Channel   Direction  Ports                           Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  clear / append point / query point
// m_        out        m_tvalid m_tready m_tdata m_tuser  query result
// cfg_      in         cfg_valid cfg_ready cfg_data     distance limit write
//
// A query reads one stored point from the point RAM per cycle, through a
// read / square / sum-compare pipe.
// Reset clears the point count and loads the default limit; the RAM is not cleared.
// A finished result waits in the output register; a query holds off new items until its
// result has moved into that register, so an m_tready stall lengthens it.
module nearest_point_search_3d_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [3*nps3d_pkg::FIELD_W-1:0]      s_tdata,   // coord_x, coord_y, coord_z
    input  logic [nps3d_pkg::OP_W-1:0]           s_tuser,   // operation

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nps3d_pkg::IDX_W+nps3d_pkg::DIST_W-1:0] m_tdata, // nearest_index, min_distance
    output logic [0:0]                           m_tuser,   // found

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nps3d_pkg::DIST_W-1:0]         cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int C = nps3d_pkg::COORD_BITS;

    logic [1:0]                      state_reg, state_next;
    logic [nps3d_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [nps3d_pkg::CNT_W-1:0]     issue_reg, issue_next;
    logic [nps3d_pkg::DIST_W-1:0]    limit_reg, limit_next;

    nps3d_pkg::coord_t               tx_reg, tx_next;
    nps3d_pkg::coord_t               ty_reg, ty_next;
    nps3d_pkg::coord_t               tz_reg, tz_next;

    logic                            rd_v_reg, rd_v_next;
    logic [nps3d_pkg::ADDR_W-1:0]    rd_idx_reg, rd_idx_next;

    logic                            sq_v_reg, sq_v_next;
    logic [nps3d_pkg::ADDR_W-1:0]    sq_idx_reg, sq_idx_next;
    logic [nps3d_pkg::SQ_W-1:0]      sqx_reg, sqx_next;
    logic [nps3d_pkg::SQ_W-1:0]      sqy_reg, sqy_next;
    logic [nps3d_pkg::SQ_W-1:0]      sqz_reg, sqz_next;

    logic [nps3d_pkg::DIST_W-1:0]    best_reg, best_next;
    logic [nps3d_pkg::ADDR_W-1:0]    best_idx_reg, best_idx_next;
    logic                            hit_reg, hit_next;

    logic                            m_valid_reg, m_valid_next;
    logic [nps3d_pkg::IDX_W-1:0]     m_idx_reg, m_idx_next;
    logic [nps3d_pkg::DIST_W-1:0]    m_dist_reg, m_dist_next;
    logic                            m_found_reg, m_found_next;

    logic                            s_xfer;
    logic                            wr_en;
    logic                            rd_en;
    logic [nps3d_pkg::PT_W-1:0]      wr_data;
    logic [nps3d_pkg::PT_W-1:0]      rd_data;
    nps3d_pkg::coord_t               in_x, in_y, in_z;
    nps3d_pkg::coord_t               px, py, pz;
    logic signed [C:0]               dx, dy, dz;
    logic [C-1:0]                    ax, ay, az;
    logic [nps3d_pkg::SUM_W-1:0]     sum;
    logic [nps3d_pkg::EXT_W-1:0]     sum_ext;
    logic [nps3d_pkg::DIST_W-1:0]    pt_dist;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;

    assign in_x = nps3d_pkg::coord_t'($signed(s_tdata[nps3d_pkg::FIELD_W-1:0]));
    assign in_y = nps3d_pkg::coord_t'($signed(s_tdata[2*nps3d_pkg::FIELD_W-1:nps3d_pkg::FIELD_W]));
    assign in_z = nps3d_pkg::coord_t'($signed(s_tdata[3*nps3d_pkg::FIELD_W-1:2*nps3d_pkg::FIELD_W]));

    assign wr_en   = s_xfer && (s_tuser == nps3d_pkg::OP_APPEND)
                     && (cnt_reg < nps3d_pkg::CNT_W'(nps3d_pkg::MAX_POINTS));
    assign wr_data = {in_z, in_y, in_x};
    assign rd_en   = (state_reg == ST_SCAN) && (issue_reg < cnt_reg);

    nps3d_ram #(
        .WIDTH (nps3d_pkg::PT_W),
        .DEPTH (nps3d_pkg::MAX_POINTS)
    ) u_points (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[nps3d_pkg::ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[nps3d_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // stage 1: absolute differences and squares
    assign px = rd_data[C-1:0];
    assign py = rd_data[2*C-1:C];
    assign pz = rd_data[3*C-1:2*C];
    assign dx = (C+1)'(tx_reg) - (C+1)'(px);
    assign dy = (C+1)'(ty_reg) - (C+1)'(py);
    assign dz = (C+1)'(tz_reg) - (C+1)'(pz);
    assign ax = dx[C] ? C'(-dx) : C'(dx);
    assign ay = dy[C] ? C'(-dy) : C'(dy);
    assign az = dz[C] ? C'(-dz) : C'(dz);

    // stage 2: sum, saturate
    assign sum     = nps3d_pkg::SUM_W'(sqx_reg) + nps3d_pkg::SUM_W'(sqy_reg)
                     + nps3d_pkg::SUM_W'(sqz_reg);
    assign sum_ext = nps3d_pkg::EXT_W'(sum);
    assign pt_dist = (sum_ext > nps3d_pkg::EXT_W'(nps3d_pkg::DIST_MAX)) ? nps3d_pkg::DIST_MAX
                     : sum_ext[nps3d_pkg::DIST_W-1:0];

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        issue_next    = issue_reg;
        limit_next    = limit_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        tz_next       = tz_reg;
        rd_v_next     = rd_en;
        rd_idx_next   = issue_reg[nps3d_pkg::ADDR_W-1:0];
        sq_v_next     = rd_v_reg;
        sq_idx_next   = rd_idx_reg;
        sqx_next      = nps3d_pkg::SQ_W'(ax) * nps3d_pkg::SQ_W'(ax);
        sqy_next      = nps3d_pkg::SQ_W'(ay) * nps3d_pkg::SQ_W'(ay);
        sqz_next      = nps3d_pkg::SQ_W'(az) * nps3d_pkg::SQ_W'(az);
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        hit_next      = hit_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_idx_next    = m_idx_reg;
        m_dist_next   = m_dist_reg;
        m_found_next  = m_found_reg;

        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        if (sq_v_reg && (pt_dist < best_reg)) begin
            best_next     = pt_dist;
            best_idx_next = sq_idx_reg;
            hit_next      = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_tuser)
                        nps3d_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        nps3d_pkg::OP_APPEND: begin
                            if (wr_en) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        nps3d_pkg::OP_QUERY: begin
                            tx_next       = in_x;
                            ty_next       = in_y;
                            tz_next       = in_z;
                            issue_next    = '0;
                            best_next     = limit_reg;
                            best_idx_next = '0;
                            hit_next      = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    issue_next = issue_reg + 1'b1;
                end else if (!rd_v_reg && !sq_v_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = nps3d_pkg::IDX_W'(best_idx_reg);
                    m_dist_next  = best_reg;
                    m_found_next = hit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            issue_reg   <= '0;
            limit_reg   <= nps3d_pkg::LIMIT_RESET;
            rd_v_reg    <= 1'b0;
            sq_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issue_reg   <= issue_next;
            limit_reg   <= limit_next;
            rd_v_reg    <= rd_v_next;
            sq_v_reg    <= sq_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        tz_reg       <= tz_next;
        rd_idx_reg   <= rd_idx_next;
        sq_idx_reg   <= sq_idx_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        sqz_reg      <= sqz_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        hit_reg      <= hit_next;
        m_idx_reg    <= m_idx_next;
        m_dist_reg   <= m_dist_next;
        m_found_reg  <= m_found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_dist_reg, m_idx_reg};
    assign m_tuser  = m_found_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= nps3d_pkg::CNT_W'(nps3d_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == ST_SCAN))
        else $error("read data returned outside scan");

    a_finish_all_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (issue_reg == cnt_reg && !rd_v_reg && !sq_v_reg))
        else $error("scan finished before all points were compared");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= cnt_reg))
        else $error("scan address past point count");

endmodule
